[hdl/ctf_pkg.sv]
// ============================================================================
// ctf_pkg: complementary tilt filter shared definitions
// Types, constants, register codes, sequencer states and arithmetic helpers.
// ============================================================================
package ctf_pkg;

    // Filter constants
    localparam int CAL_SAMPLES     = 1000;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int CNT_W           = 13;
    localparam int BSUM_W          = 28;
    localparam int BIAS_W          = 18;
    localparam int GYRO_SHIFT      = 32 - ANGLE_FRAC_BITS;
    localparam int TILT_SHIFT      = 24 - ANGLE_FRAC_BITS;

    // Bias division by reciprocal: floor(|s| * DIV_M >> DIV_K) == |s| / CAL_SAMPLES
    localparam int DIV_K   = BSUM_W + $clog2(CAL_SAMPLES);
    localparam int DIV_M_W = BSUM_W + 1;
    localparam logic [DIV_M_W-1:0] DIV_M =
        DIV_M_W'(((64'd1 << DIV_K) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    // Datapath widths
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;
    localparam int CORD_W       = 28;
    localparam int ISQ_W        = 48;
    localparam int ROOT_W       = 24;

    localparam logic [24:0] WEIGHT_ONE = 25'd16777216;

    // Register reset values
    localparam logic [31:0]        GYRO_SCALE_RST    = 32'd262423;
    localparam logic [23:0]        YAW_COUPLING_RST  = 24'd1172079;
    localparam logic [24:0]        ACCEL_WEIGHT_RST  = 25'd6711;
    localparam logic [24:0]        OUTPUT_WEIGHT_RST = 25'd1677722;

    typedef logic signed [32:0] t_mul;
    typedef logic signed [65:0] t_prod;
    typedef logic signed [67:0] t_ext;
    typedef logic signed [CORD_W-1:0] t_cord;
    typedef logic signed [31:0] t_angle;

    typedef enum logic [2:0] {
        CFG_GYRO_SCALE    = 3'd0,
        CFG_YAW_COUPLING  = 3'd1,
        CFG_ACCEL_WEIGHT  = 3'd2,
        CFG_OUTPUT_WEIGHT = 3'd3,
        CFG_PITCH_TRIM    = 3'd4,
        CFG_ROLL_TRIM     = 3'd5
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE, ST_BIAS0, ST_BIAS1, ST_BIAS2, ST_GYRO0, ST_GYRO1, ST_YAW,
        ST_CPL0, ST_CPL1, ST_CPL2, ST_CPL3, ST_CPL4, ST_SQ,
        ST_ISQ_P, ST_COR_P, ST_COR_R,
        ST_BL0, ST_BL1, ST_BL2, ST_BL3, ST_BL4, ST_BL5, ST_BL6, ST_BL7, ST_BL8,
        ST_DONE
    } t_state;

    // Round half up then shift right arithmetically
    function automatic t_ext rnd(input t_ext v, input int s);
        if (s == 0) begin
            return v;
        end
        return (v + (t_ext'(1) <<< (s - 1))) >>> s;
    endfunction

    // Clamp to signed 32 bits
    function automatic t_angle sat32(input t_ext v);
        if (v > t_ext'(64'sd2147483647)) begin
            return 32'sh7fffffff;
        end else if (v < t_ext'(-64'sd2147483648)) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // CORDIC angle table, degrees in Q.24
    function automatic t_angle atan_deg(input logic [STEP_W-1:0] i);
        case (i)
            5'd0:    return 32'sd754974720;
            5'd1:    return 32'sd445687602;
            5'd2:    return 32'sd235489088;
            5'd3:    return 32'sd119537938;
            5'd4:    return 32'sd60000934;
            5'd5:    return 32'sd30029717;
            5'd6:    return 32'sd15018523;
            5'd7:    return 32'sd7509720;
            5'd8:    return 32'sd3754917;
            5'd9:    return 32'sd1877466;
            5'd10:   return 32'sd938734;
            5'd11:   return 32'sd469367;
            5'd12:   return 32'sd234684;
            5'd13:   return 32'sd117342;
            5'd14:   return 32'sd58671;
            5'd15:   return 32'sd29335;
            5'd16:   return 32'sd14668;
            5'd17:   return 32'sd7334;
            5'd18:   return 32'sd3667;
            5'd19:   return 32'sd1833;
            5'd20:   return 32'sd917;
            5'd21:   return 32'sd458;
            5'd22:   return 32'sd229;
            5'd23:   return 32'sd115;
            default: return 32'sd0;
        endcase
    endfunction

endpackage

[hdl/ctf_sample_if.sv]
// ============================================================================
// ctf_sample_if: six-axis sample channel
// Valid/ready channel carrying one raw accelerometer and gyro sample.
// ============================================================================
interface ctf_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;

    modport source(output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                   input ready);
    modport sink(input valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z,
                 output ready);
endinterface

[hdl/ctf_result_if.sv]
// ============================================================================
// ctf_result_if: tilt result channel
// Valid/ready channel carrying fused and smoothed pitch and roll.
// ============================================================================
interface ctf_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pitch_smooth;
    logic signed [31:0] roll_smooth;
    logic signed [31:0] pitch_fused;
    logic signed [31:0] roll_fused;
    logic               accel_invalid;

    modport source(output valid, pitch_smooth, roll_smooth, pitch_fused, roll_fused,
                   accel_invalid, input ready);
    modport sink(input valid, pitch_smooth, roll_smooth, pitch_fused, roll_fused,
                 accel_invalid, output ready);
endinterface

[hdl/imu_complementary_tilt_filter_top.sv]
// ============================================================================
// imu_complementary_tilt_filter_top: gyro/accel complementary tilt filter
// Calibrates gyro bias, integrates and fuses pitch/roll with shared units.
// ============================================================================
//  channel    dir  handshake     payload
//  i_sample   in   valid/ready   accel_x/y/z, rate_x/y/z (16 s)
//  o_result   out  valid/ready   pitch/roll smooth and fused (32 s), accel_invalid
//  i_cfg_*    in   write enable  index 0..5, data 32 bits
//
//  A calibration sample is taken in the idle state, with ready kept high. A
//  filtered sample holds ready low through the shared-multiplier steps and
//  three passes (pitch root, then the pitch CORDIC beside the roll root, then
//  the roll CORDIC), then loads the output register. Synchronous active-low
//  reset restores configuration, sequencer, filter state and output valid.
//  A finished result waits in the output register; a new request is taken
//  meanwhile, and its result stalls at the end until the register is free.
// ============================================================================
module imu_complementary_tilt_filter_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ctf_sample_if.sink           i_sample,
    ctf_result_if.source         o_result,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);
    // Configuration registers
    logic [31:0]        r_gs;
    logic [23:0]        r_yc;
    logic [24:0]        r_aw;
    logic [24:0]        r_ow;
    logic signed [24:0] r_ptrim;
    logic signed [24:0] r_rtrim;

    // Control and state
    ctf_pkg::t_state                  r_state, n_state;
    logic [ctf_pkg::CNT_W-1:0]        r_count;
    logic signed [ctf_pkg::BSUM_W-1:0] r_bsum [3];
    ctf_pkg::t_angle                  r_f [2];
    ctf_pkg::t_angle                  r_s [2];
    logic                             r_seeded;
    logic                             r_out_valid;

    // Working registers
    logic signed [15:0]               r_acc_x, r_acc_y, r_acc_z;
    logic signed [15:0]               r_rate [3];
    logic                             r_inv;
    logic signed [ctf_pkg::BIAS_W-1:0] r_g [3];
    ctf_pkg::t_angle                  r_pitch, r_roll, r_c, r_ap, r_ar;
    logic [31:0]                      r_sq_p, r_sq_r;
    ctf_pkg::t_prod                   r_acc;

    // Output registers
    ctf_pkg::t_angle                  r_o_ps, r_o_rs, r_o_pf, r_o_rf;
    logic                             r_o_inv;

    // Shared units
    ctf_pkg::t_mul                    mul_a, mul_b;
    ctf_pkg::t_prod                   prod;
    logic                             isq_start, isq_busy;
    logic [ctf_pkg::ISQ_W-1:0]        isq_val;
    logic [ctf_pkg::ROOT_W-1:0]       root;
    logic                             cor_start, cor_busy;
    ctf_pkg::t_cord                   cor_x, cor_y;
    ctf_pkg::t_angle                  cor_z;

    logic                             in_acc, out_acc, calibrating;
    logic [24:0]                      wa, wa_c, wo, wo_c;
    logic [ctf_pkg::BSUM_W-1:0]       mag [3];
    logic [ctf_pkg::BIAS_W-1:0]       quot;
    ctf_pkg::t_angle                  blend_val, tilt_p, tilt_r;

    ctf_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    ctf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (isq_start),
        .i_val   (isq_val),
        .o_busy  (isq_busy),
        .o_root  (root)
    );

    ctf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cor_start),
        .i_x     (cor_x),
        .i_y     (cor_y),
        .o_busy  (cor_busy),
        .o_z     (cor_z)
    );

    // Rate minus bias: remove a truncated bias quotient from a raw rate
    function automatic logic signed [ctf_pkg::BIAS_W-1:0] unbias(
        input logic signed [15:0]         rate,
        input logic                       neg,
        input logic [ctf_pkg::BIAS_W-1:0] q
    );
        logic signed [ctf_pkg::BIAS_W-1:0] b;
        b = neg ? -$signed(q) : $signed(q);
        return ctf_pkg::BIAS_W'(rate) - b;
    endfunction

    // Handshakes
    assign in_acc           = i_sample.valid && i_sample.ready;
    assign out_acc          = o_result.valid && o_result.ready;
    assign i_sample.ready   = (r_state == ctf_pkg::ST_IDLE);
    assign calibrating      = (r_count < ctf_pkg::CNT_W'(ctf_pkg::CAL_SAMPLES));

    // Clamp weights to one and form their complements
    assign wa   = (r_aw > ctf_pkg::WEIGHT_ONE) ? ctf_pkg::WEIGHT_ONE : r_aw;
    assign wo   = (r_ow > ctf_pkg::WEIGHT_ONE) ? ctf_pkg::WEIGHT_ONE : r_ow;
    assign wa_c = ctf_pkg::WEIGHT_ONE - wa;
    assign wo_c = ctf_pkg::WEIGHT_ONE - wo;

    // Bias sum magnitudes and the quotient out of the multiplier
    for (genvar k = 0; k < 3; k++) begin : g_mag
        assign mag[k] = r_bsum[k][ctf_pkg::BSUM_W-1] ?
                        ctf_pkg::BSUM_W'(-r_bsum[k]) : ctf_pkg::BSUM_W'(r_bsum[k]);
    end
    assign quot = prod[ctf_pkg::DIV_K +: ctf_pkg::BIAS_W];

    // Blend result and trimmed accel angles
    assign blend_val = ctf_pkg::sat32(ctf_pkg::rnd(ctf_pkg::t_ext'(r_acc) +
                                                    ctf_pkg::t_ext'(prod), 24));
    assign tilt_p = ctf_pkg::sat32(ctf_pkg::rnd(ctf_pkg::t_ext'(cor_z), ctf_pkg::TILT_SHIFT)
                                   - ctf_pkg::t_ext'(r_ptrim));
    assign tilt_r = ctf_pkg::sat32(-ctf_pkg::rnd(ctf_pkg::t_ext'(cor_z), ctf_pkg::TILT_SHIFT)
                                   - ctf_pkg::t_ext'(r_rtrim));

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gs    <= ctf_pkg::GYRO_SCALE_RST;
            r_yc    <= ctf_pkg::YAW_COUPLING_RST;
            r_aw    <= ctf_pkg::ACCEL_WEIGHT_RST;
            r_ow    <= ctf_pkg::OUTPUT_WEIGHT_RST;
            r_ptrim <= '0;
            r_rtrim <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ctf_pkg::CFG_GYRO_SCALE:    r_gs    <= i_cfg_data;
                ctf_pkg::CFG_YAW_COUPLING:  r_yc    <= i_cfg_data[23:0];
                ctf_pkg::CFG_ACCEL_WEIGHT:  r_aw    <= i_cfg_data[24:0];
                ctf_pkg::CFG_OUTPUT_WEIGHT: r_ow    <= i_cfg_data[24:0];
                ctf_pkg::CFG_PITCH_TRIM:    r_ptrim <= $signed(i_cfg_data[24:0]);
                ctf_pkg::CFG_ROLL_TRIM:     r_rtrim <= $signed(i_cfg_data[24:0]);
                default: ;
            endcase
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ctf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: next state, multiplier operands and unit starts
    always_comb begin
        n_state   = r_state;
        mul_a     = '0;
        mul_b     = '0;
        isq_start = 1'b0;
        isq_val   = '0;
        cor_start = 1'b0;
        cor_x     = '0;
        cor_y     = '0;
        case (r_state)
            ctf_pkg::ST_IDLE: begin
                if (in_acc && !calibrating) begin
                    n_state = ctf_pkg::ST_BIAS0;
                end
            end
            ctf_pkg::ST_BIAS0: begin
                mul_a = ctf_pkg::t_mul'(mag[0]);
                mul_b = ctf_pkg::t_mul'(ctf_pkg::DIV_M);
                n_state = ctf_pkg::ST_BIAS1;
            end
            ctf_pkg::ST_BIAS1: begin
                mul_a = ctf_pkg::t_mul'(mag[1]);
                mul_b = ctf_pkg::t_mul'(ctf_pkg::DIV_M);
                n_state = ctf_pkg::ST_BIAS2;
            end
            ctf_pkg::ST_BIAS2: begin
                mul_a = ctf_pkg::t_mul'(mag[2]);
                mul_b = ctf_pkg::t_mul'(ctf_pkg::DIV_M);
                n_state = ctf_pkg::ST_GYRO0;
            end
            ctf_pkg::ST_GYRO0: begin
                mul_a = ctf_pkg::t_mul'(r_g[0]);
                mul_b = ctf_pkg::t_mul'(r_gs);
                n_state = ctf_pkg::ST_GYRO1;
            end
            ctf_pkg::ST_GYRO1: begin
                mul_a = ctf_pkg::t_mul'(r_g[1]);
                mul_b = ctf_pkg::t_mul'(r_gs);
                n_state = ctf_pkg::ST_YAW;
            end
            ctf_pkg::ST_YAW: begin
                mul_a = ctf_pkg::t_mul'(r_g[2]);
                mul_b = ctf_pkg::t_mul'(r_yc);
                n_state = ctf_pkg::ST_CPL0;
            end
            ctf_pkg::ST_CPL0: begin
                mul_a = ctf_pkg::t_mul'(r_acc_x);
                mul_b = ctf_pkg::t_mul'(r_acc_x);
                n_state = ctf_pkg::ST_CPL1;
            end
            ctf_pkg::ST_CPL1: begin
                mul_a = ctf_pkg::t_mul'(r_roll);
                mul_b = ctf_pkg::t_mul'(r_c);
                n_state = ctf_pkg::ST_CPL2;
            end
            ctf_pkg::ST_CPL2: begin
                mul_a = ctf_pkg::t_mul'(r_acc_y);
                mul_b = ctf_pkg::t_mul'(r_acc_y);
                n_state = ctf_pkg::ST_CPL3;
            end
            ctf_pkg::ST_CPL3: begin
                mul_a = ctf_pkg::t_mul'(r_pitch);
                mul_b = ctf_pkg::t_mul'(r_c);
                n_state = ctf_pkg::ST_CPL4;
            end
            ctf_pkg::ST_CPL4: begin
                mul_a = ctf_pkg::t_mul'(r_acc_z);
                mul_b = ctf_pkg::t_mul'(r_acc_z);
                n_state = ctf_pkg::ST_SQ;
            end
            ctf_pkg::ST_SQ: begin
                isq_start = 1'b1;
                isq_val   = {r_sq_p + prod[31:0], 16'b0};
                n_state   = ctf_pkg::ST_ISQ_P;
            end
            ctf_pkg::ST_ISQ_P: begin
                if (!isq_busy) begin
                    cor_start = 1'b1;
                    cor_x     = ctf_pkg::t_cord'(root);
                    cor_y     = ctf_pkg::t_cord'($signed({r_acc_y, 8'b0}));
                    isq_start = 1'b1;
                    isq_val   = {r_sq_r, 16'b0};
                    n_state   = ctf_pkg::ST_COR_P;
                end
            end
            ctf_pkg::ST_COR_P: begin
                if (!cor_busy && !isq_busy) begin
                    cor_start = 1'b1;
                    cor_x     = ctf_pkg::t_cord'(root);
                    cor_y     = ctf_pkg::t_cord'($signed({r_acc_x, 8'b0}));
                    n_state   = ctf_pkg::ST_COR_R;
                end
            end
            ctf_pkg::ST_COR_R: begin
                if (!cor_busy) begin
                    n_state = ctf_pkg::ST_BL0;
                end
            end
            ctf_pkg::ST_BL0: begin
                mul_a = ctf_pkg::t_mul'(r_pitch);
                mul_b = ctf_pkg::t_mul'(wa_c);
                n_state = ctf_pkg::ST_BL1;
            end
            ctf_pkg::ST_BL1: begin
                mul_a = ctf_pkg::t_mul'(r_ap);
                mul_b = ctf_pkg::t_mul'(wa);
                n_state = ctf_pkg::ST_BL2;
            end
            ctf_pkg::ST_BL2: begin
                mul_a = ctf_pkg::t_mul'(r_roll);
                mul_b = ctf_pkg::t_mul'(wa_c);
                n_state = ctf_pkg::ST_BL3;
            end
            ctf_pkg::ST_BL3: begin
                mul_a = ctf_pkg::t_mul'(r_ar);
                mul_b = ctf_pkg::t_mul'(wa);
                n_state = ctf_pkg::ST_BL4;
            end
            ctf_pkg::ST_BL4: begin
                mul_a = ctf_pkg::t_mul'(r_s[0]);
                mul_b = ctf_pkg::t_mul'(wo_c);
                n_state = ctf_pkg::ST_BL5;
            end
            ctf_pkg::ST_BL5: begin
                mul_a = ctf_pkg::t_mul'(r_f[0]);
                mul_b = ctf_pkg::t_mul'(wo);
                n_state = ctf_pkg::ST_BL6;
            end
            ctf_pkg::ST_BL6: begin
                mul_a = ctf_pkg::t_mul'(r_s[1]);
                mul_b = ctf_pkg::t_mul'(wo_c);
                n_state = ctf_pkg::ST_BL7;
            end
            ctf_pkg::ST_BL7: begin
                mul_a = ctf_pkg::t_mul'(r_f[1]);
                mul_b = ctf_pkg::t_mul'(wo);
                n_state = ctf_pkg::ST_BL8;
            end
            ctf_pkg::ST_BL8: begin
                n_state = ctf_pkg::ST_DONE;
            end
            ctf_pkg::ST_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_state = ctf_pkg::ST_IDLE;
                end
            end
            default: n_state = ctf_pkg::ST_IDLE;
        endcase
    end

    // Filter state: calibration count, bias sums, fused and smoothed angles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_bsum   <= '{default: '0};
            r_f      <= '{default: '0};
            r_s      <= '{default: '0};
            r_seeded <= 1'b0;
        end else begin
            case (r_state)
                ctf_pkg::ST_IDLE: begin
                    if (in_acc && calibrating) begin
                        r_bsum[0] <= r_bsum[0] + ctf_pkg::BSUM_W'(i_sample.rate_x);
                        r_bsum[1] <= r_bsum[1] + ctf_pkg::BSUM_W'(i_sample.rate_y);
                        r_bsum[2] <= r_bsum[2] + ctf_pkg::BSUM_W'(i_sample.rate_z);
                        r_count   <= r_count + 1'b1;
                    end
                end
                ctf_pkg::ST_BL2: r_f[0] <= r_seeded ? blend_val : r_ap;
                ctf_pkg::ST_BL4: begin
                    r_f[1]   <= r_seeded ? blend_val : r_ar;
                    r_seeded <= 1'b1;
                end
                ctf_pkg::ST_BL6: r_s[0] <= blend_val;
                ctf_pkg::ST_BL8: r_s[1] <= blend_val;
                default: ;
            endcase
        end
    end

    // Working datapath: latch the request, then consume each product
    always_ff @(posedge i_clk) begin
        case (r_state)
            ctf_pkg::ST_IDLE: begin
                if (in_acc) begin
                    r_acc_x <= i_sample.accel_x;
                    r_acc_y <= i_sample.accel_y;
                    r_acc_z <= i_sample.accel_z;
                    r_rate  <= '{i_sample.rate_x, i_sample.rate_y, i_sample.rate_z};
                    r_inv   <= (i_sample.accel_x == 16'sd0) && (i_sample.accel_y == 16'sd0)
                               && (i_sample.accel_z == 16'sd0);
                end
            end
            ctf_pkg::ST_BIAS1: r_g[0] <= unbias(r_rate[0], r_bsum[0][ctf_pkg::BSUM_W-1], quot);
            ctf_pkg::ST_BIAS2: r_g[1] <= unbias(r_rate[1], r_bsum[1][ctf_pkg::BSUM_W-1], quot);
            ctf_pkg::ST_GYRO0: r_g[2] <= unbias(r_rate[2], r_bsum[2][ctf_pkg::BSUM_W-1], quot);
            ctf_pkg::ST_GYRO1: begin
                r_pitch <= ctf_pkg::sat32(ctf_pkg::t_ext'(r_f[0]) +
                           ctf_pkg::rnd(ctf_pkg::t_ext'(prod), ctf_pkg::GYRO_SHIFT));
            end
            ctf_pkg::ST_YAW: begin
                r_roll <= ctf_pkg::sat32(ctf_pkg::t_ext'(r_f[1]) +
                          ctf_pkg::rnd(ctf_pkg::t_ext'(prod), ctf_pkg::GYRO_SHIFT));
            end
            ctf_pkg::ST_CPL0: r_c <= 32'(ctf_pkg::rnd(ctf_pkg::t_ext'(prod), 10));
            ctf_pkg::ST_CPL1: r_sq_p <= prod[31:0];
            ctf_pkg::ST_CPL2: begin
                r_pitch <= ctf_pkg::sat32(ctf_pkg::t_ext'(r_pitch) +
                           ctf_pkg::rnd(ctf_pkg::t_ext'(prod), 30));
            end
            ctf_pkg::ST_CPL3: r_sq_r <= prod[31:0];
            ctf_pkg::ST_CPL4: begin
                r_roll <= ctf_pkg::sat32(ctf_pkg::t_ext'(r_roll) -
                          ctf_pkg::rnd(ctf_pkg::t_ext'(prod), 30));
            end
            ctf_pkg::ST_SQ: r_sq_r <= r_sq_r + prod[31:0];
            ctf_pkg::ST_COR_P: begin
                if (!cor_busy && !isq_busy) begin
                    r_ap <= r_inv ? '0 : tilt_p;
                end
            end
            ctf_pkg::ST_COR_R: begin
                if (!cor_busy) begin
                    r_ar <= r_inv ? '0 : tilt_r;
                end
            end
            ctf_pkg::ST_BL1, ctf_pkg::ST_BL3, ctf_pkg::ST_BL5, ctf_pkg::ST_BL7: r_acc <= prod;
            default: ;
        endcase
    end

    // Output register: load when free, drop on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ctf_pkg::ST_DONE && (!r_out_valid || o_result.ready)) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ctf_pkg::ST_DONE && (!r_out_valid || o_result.ready)) begin
            r_o_ps  <= r_s[0];
            r_o_rs  <= r_s[1];
            r_o_pf  <= r_f[0];
            r_o_rf  <= r_f[1];
            r_o_inv <= r_inv;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.pitch_smooth  = r_o_ps;
    assign o_result.roll_smooth   = r_o_rs;
    assign o_result.pitch_fused   = r_o_pf;
    assign o_result.roll_fused    = r_o_rf;
    assign o_result.accel_invalid = r_o_inv;

    // Calibration count never passes its end
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ctf_pkg::CNT_W'(ctf_pkg::CAL_SAMPLES))
        else $error("calibration count overran");

    // Seeding only happens after calibration completes
    a_seed_after_cal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seeded |-> !calibrating)
        else $error("seeded while calibrating");

    // A calibration request never yields a result
    a_cal_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && calibrating) |=> !$rose(r_out_valid))
        else $error("result raised by a calibration request");

    // CORDIC is never restarted mid-run
    a_cordic_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_start |-> !cor_busy)
        else $error("CORDIC started while busy");
endmodule

[hdl/ctf_mul.sv]
// ============================================================================
// ctf_mul: shared signed multiplier
// One 33x33 signed multiply per cycle, product registered.
// ============================================================================
module ctf_mul (
    input  logic           i_clk,
    input  ctf_pkg::t_mul  i_a,
    input  ctf_pkg::t_mul  i_b,
    output ctf_pkg::t_prod o_prod
);
    ctf_pkg::t_prod r_prod;

    // Register the product
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;
endmodule

[hdl/ctf_isqrt.sv]
// ============================================================================
// ctf_isqrt: iterative integer square root
// Digit-by-digit root of a 48-bit value, one result bit per cycle.
// ============================================================================
module ctf_isqrt (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [ctf_pkg::ISQ_W-1:0]         i_val,
    output logic                              o_busy,
    output logic [ctf_pkg::ROOT_W-1:0]        o_root
);
    logic [ctf_pkg::ISQ_W-1:0] r_v;
    logic [ctf_pkg::ISQ_W-1:0] r_r;
    logic [ctf_pkg::ISQ_W-1:0] r_bit;
    logic                      r_busy;
    logic [ctf_pkg::ISQ_W-1:0] trial;

    assign trial = r_r + r_bit;

    // Busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_bit[0]) begin
            r_busy <= 1'b0;
        end
    end

    // Load, then compare and subtract one bit pair per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_val;
            r_r   <= '0;
            r_bit <= ctf_pkg::ISQ_W'(1) << (ctf_pkg::ISQ_W - 2);
        end else if (r_busy) begin
            if (r_v >= trial) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_r[ctf_pkg::ROOT_W-1:0];
endmodule

[hdl/ctf_cordic.sv]
// ============================================================================
// ctf_cordic: iterative vectoring CORDIC
// Rotates (x, y) toward the x axis over 24 steps and sums the angle in degrees.
// ============================================================================
module ctf_cordic (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ctf_pkg::t_cord  i_x,
    input  ctf_pkg::t_cord  i_y,
    output logic            o_busy,
    output ctf_pkg::t_angle o_z
);
    ctf_pkg::t_cord               r_x;
    ctf_pkg::t_cord               r_y;
    ctf_pkg::t_angle              r_z;
    logic [ctf_pkg::STEP_W-1:0]   r_i;
    logic                         r_busy;
    ctf_pkg::t_cord               dx;
    ctf_pkg::t_cord               dy;

    assign dx = r_y >>> r_i;
    assign dy = r_x >>> r_i;

    // Busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_i == ctf_pkg::STEP_W'(ctf_pkg::CORDIC_STEPS - 1)) begin
            r_busy <= 1'b0;
        end
    end

    // One micro-rotation per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= '0;
            r_i <= '0;
        end else if (r_busy) begin
            if (r_y >= 0) begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + ctf_pkg::atan_deg(r_i);
            end else begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - ctf_pkg::atan_deg(r_i);
            end
            r_i <= r_i + 1'b1;
        end
    end

    assign o_busy = r_busy;
    assign o_z    = r_z;
endmodule

[verif/tilt_checker.sv]
// ----------------------------------------------------------------------------
// tilt_checker: prediction and comparison for the complementary tilt filter
// Watches the sample, result and register write ports, keeps its own copy of
// the filter state, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module tilt_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ctf_sample_if       smp,
    ctf_result_if       res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ctf_pkg::*;

    localparam longint UNIT_Q24 = 64'sd16777216;
    localparam int     DEG_SHIFT = 24 - ANGLE_FRAC_BITS;

    typedef struct {
        logic signed [31:0] pitch_smooth;
        logic signed [31:0] roll_smooth;
        logic signed [31:0] pitch_fused;
        logic signed [31:0] roll_fused;
        logic               accel_invalid;
    } t_tilt_exp;

    // CORDIC rotation angles, degrees in Q.24
    longint rot_deg_q24 [24] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    // Filter registers and state
    logic [31:0] gyro_scale_r;
    logic [23:0] yaw_coupling_r;
    logic [24:0] accel_weight_r;
    logic [24:0] output_weight_r;
    longint      pitch_trim_r;
    longint      roll_trim_r;
    int          cal_count;
    longint      rate_sum [3];
    longint      fused_ang [2];
    longint      smooth_ang [2];
    bit          seeded_r;

    t_tilt_exp   tilt_q [$];
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = tilt_q.size();

    function automatic longint round_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 64'd0) begin
            if (v >= root + bitv) begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return longint'(root);
    endfunction

    // atan2(num, sqrt(a^2 + b^2)) in degrees, Q.24
    function automatic longint tilt_deg_q24(input longint num, input longint a,
                                            input longint b);
        logic [63:0] sq;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        sq = a * a + b * b;
        x  = int_sqrt(sq << 16);
        y  = num * 256;
        z  = 0;
        for (int i = 0; i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + rot_deg_q24[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - rot_deg_q24[i];
            end
        end
        return z;
    endfunction

    // Weighted mix; a weight above one acts as one
    function automatic longint mix_q24(input longint old_v, input longint new_v,
                                       input logic [24:0] w);
        longint wv;
        wv = (longint'({39'd0, w}) > UNIT_Q24) ? UNIT_Q24 : longint'({39'd0, w});
        return clamp32(round_shift(old_v * (UNIT_Q24 - wv) + new_v * wv, 24));
    endfunction

    function automatic longint trim_value(input logic [31:0] d);
        logic signed [24:0] t;
        t = d[24:0];
        return longint'(t);
    endfunction

    task automatic reset_filter();
        gyro_scale_r    = GYRO_SCALE_RST;
        yaw_coupling_r  = YAW_COUPLING_RST;
        accel_weight_r  = ACCEL_WEIGHT_RST;
        output_weight_r = OUTPUT_WEIGHT_RST;
        pitch_trim_r    = 0;
        roll_trim_r     = 0;
        cal_count       = 0;
        seeded_r        = 1'b0;
        for (int k = 0; k < 3; k++) rate_sum[k] = 0;
        for (int k = 0; k < 2; k++) begin
            fused_ang[k]  = 0;
            smooth_ang[k] = 0;
        end
        tilt_q.delete();
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [31:0] d);
        case (idx)
            CFG_GYRO_SCALE:    gyro_scale_r    = d;
            CFG_YAW_COUPLING:  yaw_coupling_r  = d[23:0];
            CFG_ACCEL_WEIGHT:  accel_weight_r  = d[24:0];
            CFG_OUTPUT_WEIGHT: output_weight_r = d[24:0];
            CFG_PITCH_TRIM:    pitch_trim_r    = trim_value(d);
            CFG_ROLL_TRIM:     roll_trim_r     = trim_value(d);
            default: ;
        endcase
    endtask

    // Advance the filter by one sample and queue the result it gives
    task automatic predict_tilt(input longint ax, input longint ay, input longint az,
                                input longint rx, input longint ry, input longint rz);
        longint    g [3];
        longint    r [3];
        longint    pitch;
        longint    roll;
        longint    cpl;
        longint    acc_p;
        longint    acc_r;
        bit        invalid;
        t_tilt_exp e;
        r[0] = rx;
        r[1] = ry;
        r[2] = rz;
        if (cal_count < CAL_SAMPLES) begin
            for (int k = 0; k < 3; k++) rate_sum[k] = rate_sum[k] + r[k];
            cal_count++;
            return;
        end
        for (int k = 0; k < 3; k++) g[k] = r[k] - rate_sum[k] / CAL_SAMPLES;

        pitch = clamp32(fused_ang[0] +
                        round_shift(g[0] * longint'({32'd0, gyro_scale_r}), GYRO_SHIFT));
        roll  = clamp32(fused_ang[1] +
                        round_shift(g[1] * longint'({32'd0, gyro_scale_r}), GYRO_SHIFT));
        cpl   = round_shift(g[2] * longint'({40'd0, yaw_coupling_r}), 10);
        pitch = clamp32(pitch + round_shift(roll * cpl, 30));
        roll  = clamp32(roll - round_shift(pitch * cpl, 30));

        invalid = (ax == 0 && ay == 0 && az == 0);
        if (invalid) begin
            acc_p = 0;
            acc_r = 0;
        end else begin
            acc_p = clamp32(round_shift(tilt_deg_q24(ay, ax, az), DEG_SHIFT) - pitch_trim_r);
            acc_r = clamp32(-round_shift(tilt_deg_q24(ax, ay, az), DEG_SHIFT) - roll_trim_r);
        end

        // First fused sample takes the accel angle outright
        if (seeded_r) begin
            fused_ang[0] = mix_q24(pitch, acc_p, accel_weight_r);
            fused_ang[1] = mix_q24(roll, acc_r, accel_weight_r);
        end else begin
            fused_ang[0] = acc_p;
            fused_ang[1] = acc_r;
            seeded_r     = 1'b1;
        end
        smooth_ang[0] = mix_q24(smooth_ang[0], fused_ang[0], output_weight_r);
        smooth_ang[1] = mix_q24(smooth_ang[1], fused_ang[1], output_weight_r);

        e.pitch_smooth  = smooth_ang[0][31:0];
        e.roll_smooth   = smooth_ang[1][31:0];
        e.pitch_fused   = fused_ang[0][31:0];
        e.roll_fused    = fused_ang[1][31:0];
        e.accel_invalid = invalid;
        tilt_q.push_back(e);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d (%h), actual %0d (%h)", $realtime,
                     name, $signed(exp_v), exp_v, $signed(act_v), act_v);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        reset_filter();
    end

    // Values read here are those before the edge's updates
    always @(posedge i_clk) begin
        t_tilt_exp e;
        if (!i_rst_n) begin
            reset_filter();
        end else begin
            if (i_cfg_we) begin
                write_register(i_cfg_idx, i_cfg_data);
            end
            // Compare the result before taking a new request
            if (res.valid && res.ready) begin
                if (tilt_q.size() == 0) begin
                    $display("%0t: result with no expectation, pitch_fused %0d",
                             $realtime, res.pitch_fused);
                    fail_count++;
                end else begin
                    e = tilt_q.pop_front();
                    check_field("pitch_smooth", e.pitch_smooth, res.pitch_smooth);
                    check_field("roll_smooth", e.roll_smooth, res.roll_smooth);
                    check_field("pitch_fused", e.pitch_fused, res.pitch_fused);
                    check_field("roll_fused", e.roll_fused, res.roll_fused);
                    check_field("accel_invalid", {31'd0, e.accel_invalid},
                                {31'd0, res.accel_invalid});
                end
            end
            if (smp.valid && smp.ready) begin
                predict_tilt(smp.accel_x, smp.accel_y, smp.accel_z,
                             smp.rate_x, smp.rate_y, smp.rate_z);
            end
        end
    end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: stimulus for the complementary tilt filter
// Resets once, calibrates the gyro bias, then sends directed and random
// samples under several register settings with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ctf_pkg::*;

    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          DRAIN_CYCLES  = 150;
    localparam int          ITEMS_PER_SET = 105;
    localparam int          POST_CAL      = 16 + 5 * ITEMS_PER_SET;
    localparam logic [2:0]  CFG_SPARE_LO  = 3'd6;
    localparam logic [2:0]  CFG_SPARE_HI  = 3'd7;
    localparam logic [31:0] TRIM_MAX      = 32'd11796480;
    localparam logic [31:0] TRIM_MIN      = -32'sd11796480;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          sent;

    ctf_sample_if smp ();
    ctf_result_if res ();

    imu_complementary_tilt_filter_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sample   (smp),
        .o_result   (res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    tilt_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .smp          (smp),
        .res          (res),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            res.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] pick_rate();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            1, 2, 3: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    function automatic logic [15:0] pick_accel();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            2, 3, 4: return 16'($urandom);
            default: return 16'($signed($urandom_range(0, 34000)) - 17000);
        endcase
    endfunction

    // Send one request; valid stays high until a gap is chosen
    task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az, input logic [15:0] rx,
                               input logic [15:0] ry, input logic [15:0] rz);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            smp.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp.valid   <= 1'b1;
        smp.accel_x <= ax;
        smp.accel_y <= ay;
        smp.accel_z <= az;
        smp.rate_x  <= rx;
        smp.rate_y  <= ry;
        smp.rate_z  <= rz;
        @(posedge i_clk);
        while (!smp.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic send_random();
        if ($urandom_range(0, 24) == 0) begin
            send_sample(16'd0, 16'd0, 16'd0, pick_rate(), pick_rate(), pick_rate());
        end else begin
            send_sample(pick_accel(), pick_accel(), pick_accel(),
                        pick_rate(), pick_rate(), pick_rate());
        end
    endtask

    // Hold off until every result is in and the block has gone quiet
    task automatic drain();
        smp.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
    endtask

    // Load one register setting; spare indexes get noise
    task automatic apply_setting(input int k);
        case (k)
            1: begin
                write_reg(CFG_GYRO_SCALE, 32'hffffffff);
                write_reg(CFG_YAW_COUPLING, 32'h00ffffff);
                write_reg(CFG_ACCEL_WEIGHT, 32'd0);
                write_reg(CFG_OUTPUT_WEIGHT, 32'd16777216);
                write_reg(CFG_PITCH_TRIM, TRIM_MAX);
                write_reg(CFG_ROLL_TRIM, TRIM_MIN);
            end
            2: begin
                write_reg(CFG_GYRO_SCALE, 32'd0);
                write_reg(CFG_YAW_COUPLING, 32'd0);
                write_reg(CFG_ACCEL_WEIGHT, 32'd16777216);
                write_reg(CFG_OUTPUT_WEIGHT, 32'd0);
                write_reg(CFG_PITCH_TRIM, TRIM_MIN);
                write_reg(CFG_ROLL_TRIM, TRIM_MAX);
            end
            3: begin
                write_reg(CFG_GYRO_SCALE, $urandom);
                write_reg(CFG_YAW_COUPLING, $urandom_range(0, 32'h00ffffff));
                write_reg(CFG_ACCEL_WEIGHT, 32'h01ffffff);
                write_reg(CFG_OUTPUT_WEIGHT, $urandom_range(32'd16777217, 32'h01ffffff));
                write_reg(CFG_PITCH_TRIM, $urandom);
                write_reg(CFG_ROLL_TRIM, $urandom);
            end
            4: begin
                write_reg(CFG_GYRO_SCALE, $urandom_range(0, 2000000));
                write_reg(CFG_YAW_COUPLING, $urandom_range(0, 32'h00ffffff));
                write_reg(CFG_ACCEL_WEIGHT, $urandom_range(0, 32'd16777216));
                write_reg(CFG_OUTPUT_WEIGHT, $urandom_range(0, 32'd16777216));
                write_reg(CFG_PITCH_TRIM, $urandom_range(0, 2 * TRIM_MAX) - TRIM_MAX);
                write_reg(CFG_ROLL_TRIM, $urandom_range(0, 2 * TRIM_MAX) - TRIM_MAX);
            end
            default: begin
                write_reg(CFG_GYRO_SCALE, GYRO_SCALE_RST);
                write_reg(CFG_YAW_COUPLING, {8'd0, YAW_COUPLING_RST});
                write_reg(CFG_ACCEL_WEIGHT, {7'd0, ACCEL_WEIGHT_RST});
                write_reg(CFG_OUTPUT_WEIGHT, {7'd0, OUTPUT_WEIGHT_RST});
                write_reg(CFG_PITCH_TRIM, 32'd0);
                write_reg(CFG_ROLL_TRIM, 32'd0);
            end
        endcase
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        i_cfg_we <= 1'b0;
    endtask

    // Pick idling by progress through the filtered samples
    task automatic set_idling(input int n);
        if (n < POST_CAL / 3) begin
            tx_idle_pct = 30;
            rx_idle_pct = 69;
        end else if (n < 2 * POST_CAL / 3) begin
            tx_idle_pct = 69;
            rx_idle_pct = 30;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_GYRO_SCALE;
        i_cfg_data  = 32'd0;
        smp.valid   = 1'b0;
        smp.accel_x = 16'd0;
        smp.accel_y = 16'd0;
        smp.accel_z = 16'd0;
        smp.rate_x  = 16'd0;
        smp.rate_y  = 16'd0;
        smp.rate_z  = 16'd0;
        sent        = 0;
        tx_idle_pct = 30;
        rx_idle_pct = 69;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apply_setting(0);

        // Calibration: rates only accumulate into the bias sums
        for (int n = 0; n < CAL_SAMPLES; n++) begin
            send_sample(16'($urandom), 16'($urandom), 16'($urandom),
                        pick_rate(), pick_rate(), pick_rate());
        end

        // Directed: seeding sample, zero vector, axis and rate extremes
        set_idling(0);
        send_sample(16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0);
        send_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff);
        send_sample(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7fff, 16'd0, 16'd0, 16'd0, 16'd0, 16'h7fff);
        send_sample(16'h8000, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000);
        send_sample(16'd0, 16'h7fff, 16'd0, 16'h7fff, 16'd0, 16'd0);
        send_sample(16'd0, 16'h8000, 16'd0, 16'h8000, 16'd0, 16'd0);
        send_sample(16'd0, 16'd0, 16'h7fff, 16'd0, 16'h7fff, 16'd0);
        send_sample(16'd0, 16'd0, 16'h8000, 16'd0, 16'h8000, 16'd0);
        send_sample(16'd0, 16'd0, 16'd0, 16'h7fff, 16'h8000, 16'h7fff);
        send_sample(16'hffff, 16'h0001, 16'hffff, 16'hffff, 16'h0001, 16'hffff);
        send_sample(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_sample(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
        send_sample(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
        send_sample(16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd0);

        // Random samples under each register setting
        for (int k = 1; k <= 5; k++) begin
            drain();
            apply_setting(k);
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                set_idling(16 + (k - 1) * ITEMS_PER_SET + n);
                send_random();
            end
        end

        smp.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
hdl/ctf_pkg.sv
hdl/ctf_sample_if.sv
hdl/ctf_result_if.sv
hdl/ctf_mul.sv
hdl/ctf_isqrt.sv
hdl/ctf_cordic.sv
hdl/imu_complementary_tilt_filter_top.sv
verif/tilt_checker.sv
verif/tb_top.sv
